@@ design/sti_pkg.sv @@
// Shared types and constants for the sorted table with insert and search.
package sti_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } sti_op_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FOUND    = 2'd1,
    STAT_ABSENT   = 2'd2,
    STAT_FULL     = 2'd3
  } sti_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SRCH_PROBE,
    ST_SRCH_CMP
  } sti_state_t;

  typedef struct packed {
    sti_op_t                     opcode;
    logic signed [VALUE_W-1:0]   value;
  } sti_cmd_t;

  typedef struct packed {
    sti_status_t       status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entry_count;
  } sti_result_t;

endpackage

@@ design/sti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/sorted_table_insert_search.sv @@
// Sorted table of signed values: ordered insertion and binary search over one RAM.
// Insert into a full or empty table finishes straight from idle; otherwise each entry above
//   the new value moves up one slot, one RAM read and compare per entry moved. A search does
//   one RAM read and compare per probe, at most ceil(log2(TABLE_DEPTH + 1)) probes.
// One command at a time; busy drops in the cycle of the done strobe, when the
//   next command may already transfer. The one-cycle result cannot be stalled.
// Synchronous reset clears state, fill count and done; unwritten RAM is never read, so no clearing.
module sorted_table_insert_search (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sti_pkg::sti_cmd_t    cmd,
  output logic                 done,
  output sti_pkg::sti_result_t result
);

  // Control state
  sti_pkg::sti_state_t           state, state_next;
  logic [sti_pkg::CNT_W-1:0]     count, count_next;
  logic                          done_next;

  // Working registers for the command in flight
  logic signed [sti_pkg::VALUE_W-1:0] value, value_next;
  logic [sti_pkg::IDX_W-1:0]     p, p_next;      // insertion slot being filled
  logic [sti_pkg::CNT_W-1:0]     lo, lo_next;    // search bounds, half-open
  logic [sti_pkg::CNT_W-1:0]     hi, hi_next;
  logic [sti_pkg::IDX_W-1:0]     mid, mid_next;
  sti_pkg::sti_result_t          result_next;

  // RAM port signals
  logic                          wr_en;
  logic [sti_pkg::IDX_W-1:0]     wr_addr;
  logic [sti_pkg::VALUE_W-1:0]   wr_data;
  logic                          rd_en;
  logic [sti_pkg::IDX_W-1:0]     rd_addr;
  logic [sti_pkg::VALUE_W-1:0]   rd_data;

  // Midpoint arithmetic: floor((lo + hi - 1) / 2)
  logic [sti_pkg::CNT_W:0]       bound_sum;
  logic [sti_pkg::IDX_W-1:0]     mid_calc;

  assign bound_sum = {1'b0, lo} + {1'b0, hi} - (sti_pkg::CNT_W+1)'(1);
  assign mid_calc  = sti_pkg::IDX_W'(bound_sum >> 1);
  assign busy      = (state != sti_pkg::ST_IDLE);

  sti_ram #(
    .WIDTH (sti_pkg::VALUE_W),
    .DEPTH (sti_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sti_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    value  <= value_next;
    p      <= p_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    value_next  = value;
    p_next      = p;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    result_next = result;
    wr_en       = 1'b0;
    wr_addr     = p;
    wr_data     = value;
    rd_en       = 1'b0;
    rd_addr     = mid_calc;

    unique case (state)
      sti_pkg::ST_IDLE: begin
        if (start) begin
          value_next = cmd.value;
          unique case (cmd.opcode)
            sti_pkg::OP_INSERT: begin
              if (count >= sti_pkg::CNT_W'(sti_pkg::TABLE_DEPTH)) begin
                // Table full: report and leave everything untouched
                result_next.status      = sti_pkg::STAT_FULL;
                result_next.position    = sti_pkg::POS_W'(count);
                result_next.entry_count = sti_pkg::POS_W'(count);
                done_next               = 1'b1;
              end else if (count == '0) begin
                // Empty table: store straight into the first slot
                wr_en                   = 1'b1;
                wr_addr                 = '0;
                wr_data                 = cmd.value;
                count_next              = sti_pkg::CNT_W'(1);
                result_next.status      = sti_pkg::STAT_INSERTED;
                result_next.position    = '0;
                result_next.entry_count = sti_pkg::POS_W'(sti_pkg::CNT_W'(1));
                done_next               = 1'b1;
              end else begin
                // Fetch the top entry; the free slot sits just above it
                rd_en      = 1'b1;
                rd_addr    = sti_pkg::IDX_W'(count - sti_pkg::CNT_W'(1));
                p_next     = sti_pkg::IDX_W'(count);
                state_next = sti_pkg::ST_INS_CMP;
              end
            end
            sti_pkg::OP_SEARCH: begin
              lo_next    = '0;
              hi_next    = count;
              state_next = sti_pkg::ST_SRCH_PROBE;
            end
            default: ;
          endcase
        end
      end

      sti_pkg::ST_INS_CMP: begin
        // rd_data holds entry p-1; move it up while it exceeds the new value
        if (value < $signed(rd_data)) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          p_next  = p - sti_pkg::IDX_W'(1);
          if (p == sti_pkg::IDX_W'(1)) begin
            state_next = sti_pkg::ST_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = p - sti_pkg::IDX_W'(2);
          end
        end else begin
          // Equal or smaller entry below: the value lands in slot p
          wr_en                   = 1'b1;
          count_next              = count + sti_pkg::CNT_W'(1);
          result_next.status      = sti_pkg::STAT_INSERTED;
          result_next.position    = sti_pkg::POS_W'(sti_pkg::CNT_W'(p));
          result_next.entry_count = sti_pkg::POS_W'(count + sti_pkg::CNT_W'(1));
          done_next               = 1'b1;
          state_next              = sti_pkg::ST_IDLE;
        end
      end

      sti_pkg::ST_INS_PUT: begin
        // Every entry moved up: store the value at the bottom
        wr_en                   = 1'b1;
        count_next              = count + sti_pkg::CNT_W'(1);
        result_next.status      = sti_pkg::STAT_INSERTED;
        result_next.position    = sti_pkg::POS_W'(sti_pkg::CNT_W'(p));
        result_next.entry_count = sti_pkg::POS_W'(count + sti_pkg::CNT_W'(1));
        done_next               = 1'b1;
        state_next              = sti_pkg::ST_IDLE;
      end

      sti_pkg::ST_SRCH_PROBE: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          mid_next   = mid_calc;
          state_next = sti_pkg::ST_SRCH_CMP;
        end else begin
          // Range empty: the low bound is the insertion point
          result_next.status      = sti_pkg::STAT_ABSENT;
          result_next.position    = sti_pkg::POS_W'(lo);
          result_next.entry_count = sti_pkg::POS_W'(count);
          done_next               = 1'b1;
          state_next              = sti_pkg::ST_IDLE;
        end
      end

      sti_pkg::ST_SRCH_CMP: begin
        if (value == $signed(rd_data)) begin
          result_next.status      = sti_pkg::STAT_FOUND;
          result_next.position    = sti_pkg::POS_W'(sti_pkg::CNT_W'(mid));
          result_next.entry_count = sti_pkg::POS_W'(count);
          done_next               = 1'b1;
          state_next              = sti_pkg::ST_IDLE;
        end else begin
          if (value < $signed(rd_data)) begin
            hi_next = sti_pkg::CNT_W'(mid);
          end else begin
            lo_next = sti_pkg::CNT_W'(mid) + sti_pkg::CNT_W'(1);
          end
          state_next = sti_pkg::ST_SRCH_PROBE;
        end
      end

      default: begin
        state_next = sti_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
